@@ hw/rtl/gbpc_pkg.sv @@
package gbpc_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CfgWidth    = 16;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned AddrWidth   = 4;
   localparam int unsigned DataWidth   = 32;

   localparam logic [CfgWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [CfgWidth-1:0] LongPressReset = 16'd1500;
   localparam logic [CfgWidth-1:0] CooldownReset  = 16'd1000;

   localparam logic [StatusWidth-1:0] StClosed    = 3'd0;
   localparam logic [StatusWidth-1:0] StOpen      = 3'd1;
   localparam logic [StatusWidth-1:0] StMoveFirst = 3'd2;
   localparam logic [StatusWidth-1:0] StMoveLast  = 3'd4;
   localparam logic [StatusWidth-1:0] StError     = 3'd5;

   typedef enum logic [1:0] {
      SCOPE_SINGLE = 2'd0,
      SCOPE_PAIRED = 2'd1,
      SCOPE_HOME   = 2'd2
   } scope_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_OPEN  = 2'd1,
      ACT_CLOSE = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_DEBOUNCE   = 2'd0,
      REG_LONG_PRESS = 2'd1,
      REG_COOLDOWN   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                   long_press;
      logic [StatusWidth-1:0] gate_one_status;
      logic [StatusWidth-1:0] gate_two_status;
      logic                   gate_one_full_open;
      logic                   gate_one_full_closed;
      logic                   gate_two_full_open;
      logic                   gate_two_full_closed;
   } sel_in_type;

   typedef struct packed {
      scope_type  command_scope;
      action_type gate_one_action;
      action_type gate_two_action;
   } cmd_type;

endpackage

@@ hw/rtl/gbpc_req_if.sv @@
interface gbpc_req_if;
   import gbpc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [TimeWidth-1:0]   now_ms;
   logic                   button_pressed;
   logic [StatusWidth-1:0] gate_one_status;
   logic [StatusWidth-1:0] gate_two_status;
   logic                   gate_one_full_open;
   logic                   gate_one_full_closed;
   logic                   gate_two_full_open;
   logic                   gate_two_full_closed;

   modport source (
      output valid, now_ms, button_pressed, gate_one_status, gate_two_status,
             gate_one_full_open, gate_one_full_closed, gate_two_full_open,
             gate_two_full_closed,
      input  ready
   );

   modport sink (
      input  valid, now_ms, button_pressed, gate_one_status, gate_two_status,
             gate_one_full_open, gate_one_full_closed, gate_two_full_open,
             gate_two_full_closed,
      output ready
   );

endinterface

@@ hw/rtl/gbpc_rsp_if.sv @@
interface gbpc_rsp_if;

   logic       valid;
   logic       ready;
   logic [1:0] command_scope;
   logic [1:0] gate_one_action;
   logic [1:0] gate_two_action;

   modport source (
      output valid, command_scope, gate_one_action, gate_two_action,
      input  ready
   );

   modport sink (
      input  valid, command_scope, gate_one_action, gate_two_action,
      output ready
   );

endinterface

@@ hw/rtl/gbpc_cmd_sel.sv @@
module gbpc_cmd_sel (
   input  gbpc_pkg::sel_in_type sel,
   output gbpc_pkg::cmd_type    cmd
);
   import gbpc_pkg::*;

   logic       one_moving;
   logic       two_moving;
   logic       any_error;
   action_type pair_action;
   action_type single_action;
   action_type home_one;
   action_type home_two;

   assign one_moving = (sel.gate_one_status >= StMoveFirst) &&
                       (sel.gate_one_status <= StMoveLast);
   assign two_moving = (sel.gate_two_status >= StMoveFirst) &&
                       (sel.gate_two_status <= StMoveLast);
   assign any_error  = (sel.gate_one_status == StError) ||
                       (sel.gate_two_status == StError);

   always_comb begin
      priority if (two_moving) begin
         single_action = ACT_STOP;
      end else if (sel.gate_two_status == StOpen) begin
         single_action = ACT_CLOSE;
      end else begin
         single_action = ACT_OPEN;
      end

      priority if (one_moving || two_moving) begin
         pair_action = ACT_STOP;
      end else if (sel.gate_one_status == StOpen || sel.gate_two_status == StOpen) begin
         pair_action = ACT_CLOSE;
      end else begin
         pair_action = ACT_OPEN;
      end

      priority if (sel.gate_one_full_closed) begin
         home_one = ACT_CLOSE;
      end else if (sel.gate_one_full_open) begin
         home_one = ACT_OPEN;
      end else begin
         home_one = ACT_NONE;
      end

      priority if (sel.gate_two_full_closed) begin
         home_two = ACT_CLOSE;
      end else if (sel.gate_two_full_open) begin
         home_two = ACT_OPEN;
      end else begin
         home_two = ACT_NONE;
      end

      priority if (!sel.long_press) begin
         cmd.command_scope   = SCOPE_SINGLE;
         cmd.gate_one_action = ACT_NONE;
         cmd.gate_two_action = single_action;
      end else if (any_error) begin
         cmd.command_scope   = SCOPE_HOME;
         cmd.gate_one_action = home_one;
         cmd.gate_two_action = home_two;
      end else begin
         cmd.command_scope   = SCOPE_PAIRED;
         cmd.gate_one_action = pair_action;
         cmd.gate_two_action = pair_action;
      end
   end

endmodule

@@ hw/rtl/gate_button_press_classifier.sv @@
// Button press classifier for two gates. Each req beat is one poll sample of
// the button and gate status; a rsp beat carries a command when a short
// release or a long hold qualifies. One sample is taken every cycle unless
// rsp backpressure holds the input register: the sample is registered, all
// debounce, hold and cooldown decisions are made from the registered sample
// and the timing state is updated as it leaves the input register, and the
// command lands in an output register.
// Backpressure on rsp stalls req only when a command is waiting and another
// sample is ready to leave the input register.
module gate_button_press_classifier (
   input  logic                            clock,
   input  logic                            reset,
   gbpc_req_if.sink                        req_chan,
   gbpc_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gbpc_pkg::AddrWidth-1:0]  paddr,
   input  logic [gbpc_pkg::DataWidth-1:0]  pwdata,
   output logic [gbpc_pkg::DataWidth-1:0]  prdata,
   output logic                            pready
);
   import gbpc_pkg::*;

   logic [CfgWidth-1:0] debounce_ff;
   logic [CfgWidth-1:0] long_press_ff;
   logic [CfgWidth-1:0] cooldown_ff;
   reg_index_type       reg_index;
   logic                cfg_write;

   logic                   in_vld_ff;
   logic [TimeWidth-1:0]   now_ff;
   logic                   pressed_ff;
   logic [StatusWidth-1:0] status_one_ff;
   logic [StatusWidth-1:0] status_two_ff;
   logic                   one_open_ff;
   logic                   one_closed_ff;
   logic                   two_open_ff;
   logic                   two_closed_ff;

   logic                 level_ff, level_in;
   logic [TimeWidth-1:0] change_time_ff, change_time_in;
   logic [TimeWidth-1:0] cmd_time_ff, cmd_time_in;
   logic [TimeWidth-1:0] start_time_ff, start_time_in;
   logic                 fired_ff, fired_in;

   logic    out_vld_ff, out_vld_in;
   cmd_type out_ff, out_in;

   logic                 advance;
   logic                 take;
   logic [TimeWidth-1:0] since_change;
   logic [TimeWidth-1:0] since_cmd;
   logic [TimeWidth-1:0] since_start;
   logic                 level_change;
   logic                 press_edge;
   logic                 cooldown_clear;
   logic                 release_cmd;
   logic                 fired_eff;
   logic [TimeWidth-1:0] hold_time;
   logic                 long_hit;
   logic                 long_cmd;
   sel_in_type           sel;
   cmd_type              cmd;

   // configuration
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[AddrWidth-1:2]);
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DebounceReset;
         long_press_ff <= LongPressReset;
         cooldown_ff   <= CooldownReset;
      end else if (cfg_write) begin
         unique case (reg_index)
            REG_DEBOUNCE:   debounce_ff   <= pwdata[CfgWidth-1:0];
            REG_LONG_PRESS: long_press_ff <= pwdata[CfgWidth-1:0];
            REG_COOLDOWN:   cooldown_ff   <= pwdata[CfgWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE:   prdata = {{(DataWidth-CfgWidth){1'b0}}, debounce_ff};
         REG_LONG_PRESS: prdata = {{(DataWidth-CfgWidth){1'b0}}, long_press_ff};
         REG_COOLDOWN:   prdata = {{(DataWidth-CfgWidth){1'b0}}, cooldown_ff};
         default:        prdata = '0;
      endcase
   end

   // handshake
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         now_ff        <= req_chan.now_ms;
         pressed_ff    <= req_chan.button_pressed;
         status_one_ff <= req_chan.gate_one_status;
         status_two_ff <= req_chan.gate_two_status;
         one_open_ff   <= req_chan.gate_one_full_open;
         one_closed_ff <= req_chan.gate_one_full_closed;
         two_open_ff   <= req_chan.gate_two_full_open;
         two_closed_ff <= req_chan.gate_two_full_closed;
      end
   end

   // decision
   assign since_change   = now_ff - change_time_ff;
   assign since_cmd      = now_ff - cmd_time_ff;
   assign since_start    = now_ff - start_time_ff;
   assign level_change   = (pressed_ff != level_ff) &&
                           (since_change > {{(TimeWidth-CfgWidth){1'b0}}, debounce_ff});
   assign press_edge     = level_change && pressed_ff;
   assign cooldown_clear = since_cmd > {{(TimeWidth-CfgWidth){1'b0}}, cooldown_ff};
   assign release_cmd    = level_change && !pressed_ff && !fired_ff && cooldown_clear;
   assign fired_eff      = press_edge ? 1'b0 : fired_ff;
   assign hold_time      = press_edge ? '0 : since_start;
   assign long_hit       = pressed_ff && !fired_eff &&
                           (hold_time >= {{(TimeWidth-CfgWidth){1'b0}}, long_press_ff});
   assign long_cmd       = long_hit && cooldown_clear;

   assign sel.long_press           = !release_cmd;
   assign sel.gate_one_status      = status_one_ff;
   assign sel.gate_two_status      = status_two_ff;
   assign sel.gate_one_full_open   = one_open_ff;
   assign sel.gate_one_full_closed = one_closed_ff;
   assign sel.gate_two_full_open   = two_open_ff;
   assign sel.gate_two_full_closed = two_closed_ff;

   gbpc_cmd_sel u_cmd_sel (
      .sel (sel),
      .cmd (cmd)
   );

   always_comb begin
      level_in       = level_ff;
      change_time_in = change_time_ff;
      cmd_time_in    = cmd_time_ff;
      start_time_in  = start_time_ff;
      fired_in       = fired_ff;
      out_in         = out_ff;
      out_vld_in     = out_vld_ff && !rsp_chan.ready;
      if (advance) begin
         if (level_change) begin
            level_in       = pressed_ff;
            change_time_in = now_ff;
         end
         if (press_edge) begin
            start_time_in = now_ff;
            fired_in      = 1'b0;
         end
         if (long_hit) begin
            fired_in = 1'b1;
         end
         if (release_cmd || long_cmd) begin
            cmd_time_in = now_ff;
            out_in      = cmd;
            out_vld_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= 1'b0;
         change_time_ff <= '0;
         cmd_time_ff    <= '0;
         start_time_ff  <= '0;
         fired_ff       <= 1'b0;
         out_vld_ff     <= 1'b0;
      end else begin
         level_ff       <= level_in;
         change_time_ff <= change_time_in;
         cmd_time_ff    <= cmd_time_in;
         start_time_ff  <= start_time_in;
         fired_ff       <= fired_in;
         out_vld_ff     <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.command_scope   = out_ff.command_scope;
   assign rsp_chan.gate_one_action = out_ff.gate_one_action;
   assign rsp_chan.gate_two_action = out_ff.gate_two_action;

endmodule
